// ===== rtl/cnlm_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package cnlm_pkg;

    // Table geometry
    localparam int TABLE_SLOTS = 16;
    localparam int SLOT_W      = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
    localparam int CNT_W       = $clog2(TABLE_SLOTS + 1);
    localparam int IDX_EXT_W   = (SLOT_W > 4) ? SLOT_W : 4;

    // Address family widths
    localparam int V4_BITS = 32;
    localparam int V6_BITS = 128;

    // Stream widths
    localparam int S_TDATA_W = 144;
    localparam int M_TDATA_W = 8;

    // Action codes carried in s_tuser
    localparam logic ACT_WRITE = 1'b0;
    localparam logic ACT_QUERY = 1'b1;

    // Input item, lowest field in the lowest bits
    typedef struct packed {
        logic [1:0]  pad;
        logic [7:0]  prefix_length;
        logic [63:0] address_low;
        logic [63:0] address_high;
        logic        is_v6;
        logic        entry_enable;
        logic [3:0]  entry_index;
    } in_item_t;

    // Result item
    typedef struct packed {
        logic [2:0] pad;
        logic [3:0] match_index;
        logic       hit;
    } out_item_t;

    // One table entry as held in the RAM
    typedef struct packed {
        logic        is_v6;
        logic [63:0] net_high;
        logic [63:0] net_low;
        logic [7:0]  prefix;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic write;     // store the accepted write item
        logic start;     // latch the accepted query, rewind the scan
        logic issue;     // read the next slot
        logic capture;   // latch the decision of the slot under compare
        logic load_out;  // move the decision into the output register
    } ctrl_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic issue_done;  // every slot has been read
        logic cand_valid;  // a slot is under compare this cycle
        logic cand_match;  // that slot matches the query
        logic cand_last;   // that slot is the last one of the table
        logic out_free;    // the output register can take a result
    } dp_status_t;

endpackage

`default_nettype wire

// ===== rtl/cnlm_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module cnlm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                                       aclk,
    input  wire logic                                       wr_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]                           wr_data,
    input  wire logic                                       rd_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic      [WIDTH-1:0]                           rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ===== rtl/cnlm_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module cnlm_ctrl
    import cnlm_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_tvalid,
    input  wire logic       s_tuser,
    output logic            s_tready,
    input  wire dp_status_t st,
    output ctrl_cmd_t       cmd
);

    state_t state_reg;
    state_t state_next;
    logic   accept;
    logic   decide;

    assign accept = s_tvalid && (state_reg == ST_IDLE);
    assign decide = st.cand_valid && (st.cand_match || st.cand_last);

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept && (s_tuser == ACT_QUERY)) begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (decide) begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (st.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        s_tready     = 1'b0;
        cmd          = '0;
        case (state_reg)
            ST_IDLE: begin
                s_tready  = 1'b1;
                cmd.write = accept && (s_tuser == ACT_WRITE);
                cmd.start = accept && (s_tuser == ACT_QUERY);
            end
            ST_SCAN: begin
                cmd.issue   = !st.issue_done && !decide;
                cmd.capture = decide;
            end
            ST_FINISH: begin
                cmd.load_out = st.out_free;
            end
            default: begin
                s_tready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/cnlm_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none

module cnlm_dp
    import cnlm_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic [S_TDATA_W-1:0] s_tdata,
    input  wire ctrl_cmd_t            cmd,
    output dp_status_t                st,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic      [M_TDATA_W-1:0] m_tdata
);

    in_item_t              in_item;
    entry_t                wr_entry;
    entry_t                ent;
    logic [IDX_EXT_W-1:0]  wr_idx_ext;
    logic                  wr_in_range;
    logic                  ram_wr_en;
    logic [SLOT_W-1:0]     wr_addr;
    logic [SLOT_W-1:0]     rd_addr;
    logic [ENTRY_W-1:0]    rd_data;

    logic [TABLE_SLOTS-1:0] valid_reg, valid_next;
    logic [CNT_W-1:0]       issue_cnt_reg, issue_cnt_next;
    logic                   data_vld_reg, data_vld_next;
    logic [SLOT_W-1:0]      data_idx_reg, data_idx_next;
    logic                   q_v6_reg, q_v6_next;
    logic [63:0]            q_hi_reg, q_hi_next;
    logic [63:0]            q_lo_reg, q_lo_next;
    logic                   res_hit_reg, res_hit_next;
    logic [3:0]             res_idx_reg, res_idx_next;
    logic                   m_tvalid_reg, m_tvalid_next;
    out_item_t              m_item_reg, m_item_next;

    logic [V4_BITS-1:0]     mask32, diff32;
    logic [V6_BITS-1:0]     mask128, diff128;
    logic                   v4_ok, v6_ok, fam_ok, match;
    logic [IDX_EXT_W-1:0]   data_idx_ext;

    assign in_item     = in_item_t'(s_tdata);
    assign wr_idx_ext  = IDX_EXT_W'(in_item.entry_index);
    assign wr_in_range = int'(wr_idx_ext) < TABLE_SLOTS;
    assign wr_addr     = wr_idx_ext[SLOT_W-1:0];
    assign ram_wr_en   = cmd.write && wr_in_range;
    assign rd_addr     = issue_cnt_reg[SLOT_W-1:0];

    assign wr_entry.is_v6    = in_item.is_v6;
    assign wr_entry.net_high = in_item.address_high;
    assign wr_entry.net_low  = in_item.address_low;
    assign wr_entry.prefix   = in_item.prefix_length;

    cnlm_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_SLOTS)
    ) u_table (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_entry),
        .rd_en   (cmd.issue),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Prefix compare of the slot read in the previous cycle
    always_comb begin
        ent     = entry_t'(rd_data);
        mask32  = ~({V4_BITS{1'b1}} >> ent.prefix);
        mask128 = ~({V6_BITS{1'b1}} >> ent.prefix);
        diff32  = q_lo_reg[V4_BITS-1:0] ^ ent.net_low[V4_BITS-1:0];
        diff128 = {q_hi_reg, q_lo_reg} ^ {ent.net_high, ent.net_low};
        v4_ok   = (ent.prefix <= 8'(V4_BITS)) && ((diff32 & mask32) == '0);
        v6_ok   = (ent.prefix <= 8'(V6_BITS)) && ((diff128 & mask128) == '0);
        fam_ok  = ent.is_v6 == q_v6_reg;
        match   = data_vld_reg && valid_reg[data_idx_reg] && fam_ok
                  && (q_v6_reg ? v6_ok : v4_ok);
    end

    assign data_idx_ext = IDX_EXT_W'(data_idx_reg);

    always_comb begin
        st.issue_done = issue_cnt_reg == CNT_W'(TABLE_SLOTS);
        st.cand_valid = data_vld_reg;
        st.cand_match = match;
        st.cand_last  = data_idx_reg == SLOT_W'(TABLE_SLOTS - 1);
        st.out_free   = !m_tvalid_reg || m_tready;
    end

    always_comb begin
        valid_next     = valid_reg;
        issue_cnt_next = issue_cnt_reg;
        q_v6_next      = q_v6_reg;
        q_hi_next      = q_hi_reg;
        q_lo_next      = q_lo_reg;
        res_hit_next   = res_hit_reg;
        res_idx_next   = res_idx_reg;
        m_tvalid_next  = m_tvalid_reg;
        m_item_next    = m_item_reg;
        data_vld_next  = cmd.issue;
        data_idx_next  = cmd.issue ? rd_addr : data_idx_reg;

        if (ram_wr_en) begin
            valid_next[wr_addr] = in_item.entry_enable;
        end
        if (cmd.start) begin
            issue_cnt_next = '0;
            q_v6_next      = in_item.is_v6;
            q_hi_next      = in_item.address_high;
            q_lo_next      = in_item.address_low;
        end else if (cmd.issue) begin
            issue_cnt_next = issue_cnt_reg + CNT_W'(1);
        end
        if (cmd.capture) begin
            res_hit_next = match;
            res_idx_next = match ? data_idx_ext[3:0] : 4'd0;
        end
        if (cmd.load_out) begin
            m_tvalid_next           = 1'b1;
            m_item_next.pad         = '0;
            m_item_next.hit         = res_hit_reg;
            m_item_next.match_index = res_idx_reg;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg     <= '0;
            issue_cnt_reg <= '0;
            data_vld_reg  <= 1'b0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            valid_reg     <= valid_next;
            issue_cnt_reg <= issue_cnt_next;
            data_vld_reg  <= data_vld_next;
            m_tvalid_reg  <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        data_idx_reg <= data_idx_next;
        q_v6_reg     <= q_v6_next;
        q_hi_reg     <= q_hi_next;
        q_lo_reg     <= q_lo_next;
        res_hit_reg  <= res_hit_next;
        res_idx_reg  <= res_idx_next;
        m_item_reg   <= m_item_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_item_reg;

    // A reported hit always points at a slot that was valid when compared
    a_hit_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.capture && match |-> valid_reg[data_idx_reg])
        else $error("hit captured on an invalid slot");

    // The scan never runs past the end of the table
    a_cnt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.issue |-> (issue_cnt_reg < CNT_W'(TABLE_SLOTS)))
        else $error("slot read beyond the table");

    // A miss carries slot zero
    a_miss_idx: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg && !m_item_reg.hit |-> (m_item_reg.match_index == 4'd0))
        else $error("miss result with nonzero index");

endmodule

`default_nettype wire

// ===== rtl/cidr_network_list_match.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Channel  Dir  Handshake            Payload
// s_       in   s_tvalid / s_tready  s_tuser: action; s_tdata: entry item or query
// m_       out  m_tvalid / m_tready  m_tdata: hit, match_index
//
// A write item is stored in its slot on the accepting edge.
// A query scans the table from slot 0 up, one slot per cycle on its single read
// port, and stops at the first matching slot, or at the last slot on a miss;
// the lowest matching slot wins.
// Reset clears all slot valid bits and the output valid flag at once.
// The result waits in the output register; writes keep flowing meanwhile, a
// following query scans and then holds until that register is free.

module cidr_network_list_match
    import cnlm_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    // from bit 0: entry_index[3:0], entry_enable, is_v6, address_high[63:0],
    // address_low[63:0], prefix_length[7:0], zero fill
    input  wire logic [S_TDATA_W-1:0] s_tdata,
    // action: 0 write entry, 1 query
    input  wire logic                 s_tuser,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    // from bit 0: hit, match_index[3:0], zero fill
    output logic      [M_TDATA_W-1:0] m_tdata
);

    ctrl_cmd_t  cmd;
    dp_status_t st;

    // Sequence the write, scan and result hand-off
    cnlm_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tuser  (s_tuser),
        .s_tready (s_tready),
        .st       (st),
        .cmd      (cmd)
    );

    // Hold the table, compare slots, register the result
    cnlm_dp u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .cmd      (cmd),
        .st       (st),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

module tb;
    import cnlm_pkg::*;

    localparam int N_ITEMS     = 600;
    localparam int STALL_LIMIT = 4000;
    localparam int IDLE_PCT    = 36;
    localparam int SETTLE_CYC  = 2 * TABLE_SLOTS + 16;

    // One directed stimulus row; typed_res marks rows whose result is written out here
    typedef struct packed {
        logic        act;
        logic [3:0]  idx;
        logic        en;
        logic        v6;
        logic [63:0] hi;
        logic [63:0] lo;
        logic [7:0]  pfx;
        logic        typed_res;
        logic        t_hit;
        logic [3:0]  t_idx;
    } dir_row_t;

    localparam int N_DIR = 24;
    localparam dir_row_t DIR_ROWS [N_DIR] = '{
        // empty table: both families miss
        '{ACT_QUERY, 4'd0,  1'b0, 1'b0, 64'h0, 64'h0, 8'd0, 1'b1, 1'b0, 4'd0},
        '{ACT_QUERY, 4'd0,  1'b0, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF,
          8'd0, 1'b1, 1'b0, 4'd0},
        // IPv4 /16 in the top slot; upper address bits must not matter
        '{ACT_WRITE, 4'd15, 1'b1, 1'b0, 64'h0, 64'h0000_0000_C0A8_0000, 8'd16, 1'b0, 1'b0, 4'd0},
        '{ACT_QUERY, 4'd0,  1'b0, 1'b0, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_C0A8_FFFF,
          8'd0, 1'b0, 1'b0, 4'd0},
        // same address as IPv6: family differs
        '{ACT_QUERY, 4'd0,  1'b0, 1'b1, 64'h0, 64'h0000_0000_C0A8_FFFF, 8'd0, 1'b0, 1'b0, 4'd0},
        // IPv4 prefix above 32 never matches
        '{ACT_WRITE, 4'd3,  1'b1, 1'b0, 64'h0, 64'h0000_0000_C0A8_0001, 8'd33, 1'b0, 1'b0, 4'd0},
        '{ACT_QUERY, 4'd0,  1'b0, 1'b0, 64'h0, 64'h0000_0000_C0A8_0001, 8'd0, 1'b0, 1'b0, 4'd0},
        // full-length IPv6 host route, exact and off by the last bit
        '{ACT_WRITE, 4'd0,  1'b1, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF,
          8'd128, 1'b0, 1'b0, 4'd0},
        '{ACT_QUERY, 4'd0,  1'b0, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF,
          8'd0, 1'b0, 1'b0, 4'd0},
        '{ACT_QUERY, 4'd0,  1'b0, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFE,
          8'd0, 1'b0, 1'b0, 4'd0},
        // IPv6 prefix above 128 never matches; prefix zero catches every IPv6 address
        '{ACT_WRITE, 4'd1,  1'b1, 1'b1, 64'h0, 64'h0, 8'd255, 1'b0, 1'b0, 4'd0},
        '{ACT_WRITE, 4'd2,  1'b1, 1'b1, 64'h5A5A_0F0F_1234_8765, 64'h8000_0000_0000_0001,
          8'd0, 1'b0, 1'b0, 4'd0},
        '{ACT_QUERY, 4'd0,  1'b0, 1'b1, 64'h0, 64'h0, 8'd0, 1'b0, 1'b0, 4'd0},
        // IPv4 /32 all ones
        '{ACT_WRITE, 4'd4,  1'b1, 1'b0, 64'h0, 64'h0000_0000_FFFF_FFFF, 8'd32, 1'b0, 1'b0, 4'd0},
        '{ACT_QUERY, 4'd0,  1'b0, 1'b0, 64'h0, 64'hFFFF_FFFF_FFFF_FFFF, 8'd0, 1'b0, 1'b0, 4'd0},
        // IPv4 prefix zero catches every IPv4 address
        '{ACT_WRITE, 4'd5,  1'b1, 1'b0, 64'h0, 64'h0, 8'd0, 1'b0, 1'b0, 4'd0},
        '{ACT_QUERY, 4'd0,  1'b0, 1'b0, 64'h0, 64'h0000_0000_1234_5678, 8'd0, 1'b0, 1'b0, 4'd0},
        // disable the IPv6 catch-all again
        '{ACT_WRITE, 4'd2,  1'b0, 1'b1, 64'h0, 64'h0, 8'd0, 1'b0, 1'b0, 4'd0},
        '{ACT_QUERY, 4'd0,  1'b0, 1'b1, 64'h0, 64'h0, 8'd0, 1'b0, 1'b0, 4'd0},
        // /64 boundary, then /65 reaching into the low half
        '{ACT_WRITE, 4'd6,  1'b1, 1'b1, 64'h2001_0DB8_0000_0000, 64'h0123_4567_89AB_CDEF,
          8'd64, 1'b0, 1'b0, 4'd0},
        '{ACT_QUERY, 4'd0,  1'b0, 1'b1, 64'h2001_0DB8_0000_0000, 64'hFEDC_BA98_7654_3210,
          8'd0, 1'b0, 1'b0, 4'd0},
        '{ACT_WRITE, 4'd7,  1'b1, 1'b1, 64'hAAAA_AAAA_AAAA_AAAA, 64'h8000_0000_0000_0000,
          8'd65, 1'b0, 1'b0, 4'd0},
        '{ACT_QUERY, 4'd0,  1'b0, 1'b1, 64'hAAAA_AAAA_AAAA_AAAA, 64'h7FFF_FFFF_FFFF_FFFF,
          8'd0, 1'b0, 1'b0, 4'd0},
        '{ACT_QUERY, 4'd0,  1'b0, 1'b1, 64'hAAAA_AAAA_AAAA_AAAA, 64'hFFFF_FFFF_FFFF_FFFF,
          8'd0, 1'b0, 1'b0, 4'd0}
    };

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic                 s_tuser  = ACT_WRITE;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;

    // Local copy of the network table
    logic         tbl_valid [TABLE_SLOTS];
    logic         tbl_v6    [TABLE_SLOTS];
    logic [127:0] tbl_net   [TABLE_SLOTS];
    logic [7:0]   tbl_pfx   [TABLE_SLOTS];

    out_item_t lookup_q [$];
    bit        no_idle     = 1'b0;
    int        err_count   = 0;
    int        n_writes    = 0;
    int        n_lookups   = 0;
    int        n_hits      = 0;
    int        stall_cycles = 0;

    cidr_network_list_match dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #1 aclk = ~aclk;

    // Leftmost p bits set, p clipped to the family width
    function automatic logic [127:0] net_mask(input logic v6, input int p);
        logic [127:0] m;
        int           w;
        w = v6 ? 128 : 32;
        if (p > w)
            p = w;
        if (p == 0)
            m = '0;
        else if (v6)
            m = ~128'd0 << (128 - p);
        else
            m = {96'd0, ~32'd0 << (32 - p)};
        return m;
    endfunction

    // First valid slot of the right family whose prefix covers the address
    function automatic out_item_t lookup_table(input logic v6, input logic [127:0] addr);
        out_item_t res;
        int        p;
        res = '0;
        for (int s = TABLE_SLOTS - 1; s >= 0; s--) begin
            p = int'(tbl_pfx[s]);
            if (tbl_valid[s] && tbl_v6[s] == v6 && p <= (v6 ? 128 : 32)) begin
                if (((addr ^ tbl_net[s]) & net_mask(v6, p)) == '0) begin
                    res.hit         = 1'b1;
                    res.match_index = s[3:0];
                end
            end
        end
        return res;
    endfunction

    task automatic report_mismatch(input string what);
        $display("mismatch at %0t: %s", $time, what);
        err_count++;
    endtask

    // Present one item from a falling edge on; return at the falling edge after accept
    task automatic send_item(input logic act, input in_item_t it,
                             input logic use_typed, input out_item_t typed_res);
        while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= it;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        if (act == ACT_WRITE) begin
            tbl_valid[it.entry_index] = it.entry_enable;
            tbl_v6[it.entry_index]    = it.is_v6;
            tbl_net[it.entry_index]   = {it.address_high, it.address_low};
            tbl_pfx[it.entry_index]   = it.prefix_length;
            n_writes++;
        end else begin
            lookup_q.push_back(use_typed ? typed_res :
                               lookup_table(it.is_v6, {it.address_high, it.address_low}));
            n_lookups++;
        end
        @(negedge aclk);
    endtask

    // Hold the sender off until every pending lookup has answered
    task automatic drain_lookups();
        s_tvalid <= 1'b0;
        while (lookup_q.size() != 0)
            @(negedge aclk);
    endtask

    // Mostly writes and lookups aimed at stored networks, some near misses and noise
    task automatic make_random_item(output logic act, output in_item_t it);
        int           r;
        int           s;
        int           p;
        int           r2;
        logic [127:0] addr;
        logic [127:0] keep;
        it   = '0;
        r    = $urandom_range(99);
        addr = {$urandom, $urandom, $urandom, $urandom};
        if (r < 30) begin
            act             = ACT_WRITE;
            it.entry_index  = 4'($urandom_range(TABLE_SLOTS - 1));
            it.entry_enable = ($urandom_range(99) < 85);
            it.is_v6        = 1'($urandom_range(1));
            r2              = $urandom_range(99);
            if (r2 < 80)
                it.prefix_length = 8'($urandom_range(it.is_v6 ? 128 : 32));
            else if (r2 < 90)
                it.prefix_length = $urandom_range(1) ? 8'd0 : (it.is_v6 ? 8'd128 : 8'd32);
            else
                it.prefix_length = 8'($urandom_range(255));
        end else begin
            act = ACT_QUERY;
            s   = $urandom_range(TABLE_SLOTS - 1);
            if (r < 85) begin
                it.is_v6 = tbl_v6[s];
                p        = int'(tbl_pfx[s]);
                keep     = net_mask(tbl_v6[s], p);
                addr     = (tbl_net[s] & keep) | (addr & ~keep);
                // flip one bit inside the prefix for a near miss
                if (r >= 75 && keep != '0) begin
                    if (tbl_v6[s])
                        addr[127 - $urandom_range((p > 128 ? 128 : p) - 1)] ^= 1'b1;
                    else
                        addr[31 - $urandom_range((p > 32 ? 32 : p) - 1)] ^= 1'b1;
                end
            end else begin
                it.is_v6 = 1'($urandom_range(1));
            end
        end
        it.address_high = addr[127:64];
        it.address_low  = addr[63:0];
    endtask

    always @(negedge aclk)
        m_tready <= no_idle || ($urandom_range(99) >= IDLE_PCT);

    always @(posedge aclk) begin : result_check
        out_item_t got;
        out_item_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata;
            if (lookup_q.size() == 0) begin
                report_mismatch($sformatf("result hit=%0b idx=%0d with no lookup pending",
                                          got.hit, got.match_index));
            end else begin
                want = lookup_q.pop_front();
                if (got.hit !== want.hit)
                    report_mismatch($sformatf("hit %0b, expected %0b", got.hit, want.hit));
                if (got.match_index !== want.match_index)
                    report_mismatch($sformatf("match_index %0d, expected %0d",
                                              got.match_index, want.match_index));
            end
            if (got.hit === 1'b1)
                n_hits++;
        end
    end

    // Count cycles in which neither channel moves an item
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("watchdog: no item moved for %0d cycles", STALL_LIMIT);
            $display("tb: errors");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin : stimulus
        in_item_t  it;
        out_item_t typed;
        logic      act;
        for (int i = 0; i < TABLE_SLOTS; i++) begin
            tbl_valid[i] = 1'b0;
            tbl_v6[i]    = 1'b0;
            tbl_net[i]   = '0;
            tbl_pfx[i]   = '0;
        end

        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        foreach (DIR_ROWS[i]) begin
            it                   = '0;
            it.entry_index       = DIR_ROWS[i].idx;
            it.entry_enable      = DIR_ROWS[i].en;
            it.is_v6             = DIR_ROWS[i].v6;
            it.address_high      = DIR_ROWS[i].hi;
            it.address_low       = DIR_ROWS[i].lo;
            it.prefix_length     = DIR_ROWS[i].pfx;
            typed                = '0;
            typed.hit            = DIR_ROWS[i].t_hit;
            typed.match_index    = DIR_ROWS[i].t_idx;
            send_item(DIR_ROWS[i].act, it, DIR_ROWS[i].typed_res, typed);
        end
        drain_lookups();

        for (int i = 0; i < N_ITEMS; i++) begin
            no_idle = (i >= 250 && i < 350);
            if (i % 150 == 149)
                drain_lookups();
            make_random_item(act, it);
            send_item(act, it, 1'b0, '0);
        end
        no_idle = 1'b0;
        drain_lookups();
        repeat (SETTLE_CYC) @(posedge aclk);

        if (lookup_q.size() != 0)
            report_mismatch($sformatf("%0d lookups never answered", lookup_q.size()));

        $display("summary: %0d table writes and %0d lookups, %0d answered with a hit",
                 n_writes, n_lookups, n_hits);
        $display("summary: both families, prefix 0 to 255, steady and stalled traffic");
        if (err_count == 0) begin
            $display("tb: clean");
        end else begin
            $display("tb: errors");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/cnlm_pkg.sv
rtl/cnlm_ram.sv
rtl/cnlm_ctrl.sv
rtl/cnlm_dp.sv
rtl/cidr_network_list_match.sv
tb/tb.sv
